// File: rtl/core/pointer_gesture_recognizer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pointer gesture recognizer
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef POINTER_GESTURE_RECOGNIZER_CORE_DEFINES_SVH
`define POINTER_GESTURE_RECOGNIZER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge while reset is released.
`define PGR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PGR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PGR_ASSERT(lbl, clk, rst_n, prop, msg)
`define PGR_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/core/pgr_pkg.sv
// ----------------------------------------------------------------------------
// Pointer gesture recognizer package
// Field widths, event and register codes, and reset values.
// ----------------------------------------------------------------------------
package pgr_pkg;

    localparam int unsigned POS_W     = 16;
    localparam int unsigned DT_W      = 16;
    localparam int unsigned DELTA_W   = 17;
    localparam int unsigned GEST_W    = 2;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned THR_W     = 15;
    localparam int unsigned THR_SQ_W  = 2 * THR_W;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    // Time counters only need to tell values above the largest 16-bit limit.
    localparam int unsigned TIME_W    = DT_W + 1;

    localparam int unsigned S_TDATA_W = 3 * POS_W + DT_W;
    localparam int unsigned M_DATA_W  = 3 * DELTA_W;
    localparam int unsigned M_TDATA_W = ((M_DATA_W + 7) / 8) * 8;
    localparam int unsigned M_TUSER_W = GEST_W + 1;

    // Event kinds carried in the input tuser.
    localparam logic [MODE_W-1:0] MODE_DOWN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd3;

    // Reported gesture codes.
    localparam logic [GEST_W-1:0] GEST_TAP    = 2'd0;
    localparam logic [GEST_W-1:0] GEST_DOUBLE = 2'd1;
    localparam logic [GEST_W-1:0] GEST_LONG   = 2'd2;
    localparam logic [GEST_W-1:0] GEST_DRAG   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_THRESHOLD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TAP_WINDOW  = 2'd2;

    localparam logic [THR_SQ_W-1:0]  RST_THR_SQ      = 30'd100;
    localparam logic [DT_W-1:0]      RST_LONG_PRESS  = 16'd500;
    localparam logic [DT_W-1:0]      RST_DOUBLE_TAP  = 16'd300;
    localparam logic [TIME_W-1:0]    RST_SINCE_TAP   = 17'd1000;

    typedef struct packed {
        logic [DT_W-1:0]         dt_ms;
        logic signed [POS_W-1:0] pos_z;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
        logic [MODE_W-1:0]       mode;
    } t_event;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta_z;
        logic signed [DELTA_W-1:0] delta_y;
        logic signed [DELTA_W-1:0] delta_x;
        logic                      drag_ended;
        logic [GEST_W-1:0]         gesture;
    } t_report;

endpackage

// File: rtl/core/pointer_gesture_recognizer_core.sv
// ----------------------------------------------------------------------------
// Pointer gesture recognizer core
// Turns pointer events into tap, double tap, long press and drag reports.
// ----------------------------------------------------------------------------
// One pointer event is taken per clock cycle while the result register is not
// stalled. When an event causes a report, the event is first held in the input
// register, and its report is then written to the result register and held
// there until it is taken. The per-event stage holds the
// distance check, three 16 x 16 squarers feeding a sum that is compared
// against the squared drag threshold, and that path sets the clock rate. The
// squared threshold is formed when the threshold register is written.
// A stalled result register holds the stream back one stage at a time.
`include "pointer_gesture_recognizer_core_defines.svh"

module pointer_gesture_recognizer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pgr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pgr_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    // Event stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata, low bit up: pos_x[15:0], pos_y[15:0], pos_z[15:0], dt_ms[15:0]
    input  logic [pgr_pkg::S_TDATA_W-1:0]       i_s_tdata,
    // tuser: mode[1:0]
    input  logic [pgr_pkg::MODE_W-1:0]          i_s_tuser,
    // Report stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata, low bit up: delta_x[16:0], delta_y[16:0], delta_z[16:0], zero pad
    output logic [pgr_pkg::M_TDATA_W-1:0]       o_m_tdata,
    // tuser, low bit up: gesture[1:0], drag_ended
    output logic [pgr_pkg::M_TUSER_W-1:0]       o_m_tuser
);
    import pgr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_POSSIBLE, PH_BEGAN, PH_CHANGED, PH_ENDED
    } t_phase;

    typedef enum logic [2:0] {
        KD_NONE, KD_TAP, KD_DOUBLE, KD_LONG, KD_DRAG
    } t_kind;

    // Configuration.
    logic [THR_SQ_W-1:0] r_thr_sq;
    logic [DT_W-1:0]     r_long_press;
    logic [DT_W-1:0]     r_double_tap;
    logic [THR_W-1:0]    w_thr;

    // Recognizer state.
    t_phase                    r_phase, n_phase;
    t_kind                     r_kind, n_kind;
    logic signed [POS_W-1:0]   r_start [3];
    logic signed [POS_W-1:0]   n_start [3];
    logic signed [POS_W-1:0]   r_last [3];
    logic signed [POS_W-1:0]   n_last [3];
    logic [TIME_W-1:0]         r_press, n_press;
    logic [TIME_W-1:0]         r_since, n_since;
    logic [1:0]                r_taps, n_taps;

    // Pipeline registers.
    logic    r_in_valid;
    t_event  r_in;
    logic    r_out_valid;
    t_report r_out;

    logic                      w_proc;
    logic                      w_emit;
    t_report                   w_rep;
    logic signed [POS_W-1:0]   w_pos [3];
    logic [POS_W-1:0]          w_mag [3];
    logic [2*POS_W-1:0]        w_sq [3];
    logic [2*POS_W+1:0]        w_sum;
    logic                      w_within;
    logic [TIME_W:0]           w_press_sum;
    logic [TIME_W:0]           w_since_sum;
    logic [TIME_W-1:0]         w_press_adv;
    logic [TIME_W-1:0]         w_since_adv;
    logic [1:0]                w_taps_inc;

    assign w_thr       = i_cfg_data[THR_W-1:0];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_sq     <= RST_THR_SQ;
            r_long_press <= RST_LONG_PRESS;
            r_double_tap <= RST_DOUBLE_TAP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DRAG_THRESHOLD:     r_thr_sq     <= w_thr * w_thr;
                CFG_LONG_PRESS_TIMEOUT: r_long_press <= i_cfg_data;
                CFG_DOUBLE_TAP_WINDOW:  r_double_tap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The event in the input register moves on when the result register can
    // take whatever it produces.
    assign w_proc     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_proc;

    assign w_pos[0] = r_in.pos_x;
    assign w_pos[1] = r_in.pos_y;
    assign w_pos[2] = r_in.pos_z;

    always_comb begin
        logic signed [POS_W:0] d;
        for (int i = 0; i < 3; i++) begin
            d = {w_pos[i][POS_W-1], w_pos[i]} - {r_start[i][POS_W-1], r_start[i]};
            // The magnitude of a 16-bit difference fits in 16 bits.
            w_mag[i] = d[POS_W] ? POS_W'(-d) : POS_W'(d);
            w_sq[i]  = w_mag[i] * w_mag[i];
        end
        w_sum = {2'b00, w_sq[0]} + {2'b00, w_sq[1]} + {2'b00, w_sq[2]};
    end

    assign w_within = w_sum <= {4'd0, r_thr_sq};

    // Saturating time advance; saturating above every 16-bit limit keeps all
    // comparisons exact.
    assign w_press_sum = {1'b0, r_press} + {2'b00, r_in.dt_ms};
    assign w_since_sum = {1'b0, r_since} + {2'b00, r_in.dt_ms};
    assign w_press_adv = w_press_sum[TIME_W] ? {TIME_W{1'b1}} : w_press_sum[TIME_W-1:0];
    assign w_since_adv = w_since_sum[TIME_W] ? {TIME_W{1'b1}} : w_since_sum[TIME_W-1:0];
    assign w_taps_inc  = (r_taps == 2'd3) ? 2'd3 : r_taps + 2'd1;

    always_comb begin
        logic [GEST_W-1:0] gest;
        n_phase = r_phase;
        n_kind  = r_kind;
        n_start = r_start;
        n_last  = r_last;
        n_press = w_press_adv;
        n_since = w_since_adv;
        n_taps  = r_taps;
        w_emit  = 1'b0;
        gest    = GEST_TAP;

        if (r_phase == PH_POSSIBLE && w_press_adv > {1'b0, r_long_press}
                && r_in.mode != MODE_DOWN && w_within) begin
            n_last  = w_pos;
            n_kind  = KD_LONG;
            n_phase = PH_ENDED;
            n_taps  = 2'd0;
            w_emit  = 1'b1;
            gest    = GEST_LONG;
        end else begin
            case (r_in.mode)
                MODE_DOWN: begin
                    if (w_since_adv > {1'b0, r_double_tap}) begin
                        n_taps = 2'd0;
                    end
                    n_phase = PH_POSSIBLE;
                    n_start = w_pos;
                    n_last  = w_pos;
                    n_press = '0;
                end
                MODE_MOVE: begin
                    if (r_phase inside {PH_POSSIBLE, PH_BEGAN, PH_CHANGED}) begin
                        if (!w_within && r_kind != KD_DRAG) begin
                            // Drag begins; the last point stays as it was.
                            n_kind  = KD_DRAG;
                            n_phase = PH_BEGAN;
                            w_emit  = 1'b1;
                            gest    = GEST_DRAG;
                        end else begin
                            if (!w_within) begin
                                n_phase = PH_CHANGED;
                            end
                            n_last = w_pos;
                        end
                    end
                end
                MODE_UP: begin
                    if (r_phase == PH_POSSIBLE) begin
                        n_taps  = w_taps_inc;
                        n_kind  = w_taps_inc[1] ? KD_DOUBLE : KD_TAP;
                        n_phase = PH_ENDED;
                        n_since = '0;
                        w_emit  = 1'b1;
                        gest    = w_taps_inc[1] ? GEST_DOUBLE : GEST_TAP;
                    end else if (r_phase inside {PH_BEGAN, PH_CHANGED}) begin
                        n_phase = PH_ENDED;
                        w_emit  = 1'b1;
                        case (r_kind)
                            KD_TAP:    gest = GEST_TAP;
                            KD_DOUBLE: gest = GEST_DOUBLE;
                            KD_LONG:   gest = GEST_LONG;
                            KD_DRAG:   gest = GEST_DRAG;
                            default:   gest = GEST_TAP;
                        endcase
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end

        w_rep.gesture    = gest;
        w_rep.drag_ended = (n_phase == PH_ENDED);
        w_rep.delta_x    = {n_last[0][POS_W-1], n_last[0]} - {n_start[0][POS_W-1], n_start[0]};
        w_rep.delta_y    = {n_last[1][POS_W-1], n_last[1]} - {n_start[1][POS_W-1], n_start[1]};
        w_rep.delta_z    = {n_last[2][POS_W-1], n_last[2]} - {n_start[2][POS_W-1], n_start[2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_kind      <= KD_NONE;
            r_start     <= '{default: '0};
            r_last      <= '{default: '0};
            r_press     <= '0;
            r_since     <= RST_SINCE_TAP;
            r_taps      <= 2'd0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_proc) begin
                r_out_valid <= w_emit;
                r_phase     <= n_phase;
                r_kind      <= n_kind;
                r_start     <= n_start;
                r_last      <= n_last;
                r_press     <= n_press;
                r_since     <= n_since;
                r_taps      <= n_taps;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.mode  <= i_s_tuser;
            r_in.pos_x <= i_s_tdata[POS_W-1:0];
            r_in.pos_y <= i_s_tdata[2*POS_W-1:POS_W];
            r_in.pos_z <= i_s_tdata[3*POS_W-1:2*POS_W];
            r_in.dt_ms <= i_s_tdata[3*POS_W+DT_W-1:3*POS_W];
        end
        if (w_proc && w_emit) begin
            r_out <= w_rep;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = {r_out.drag_ended, r_out.gesture};
    assign o_m_tdata  = {{(M_TDATA_W - M_DATA_W){1'b0}},
                         r_out.delta_z, r_out.delta_y, r_out.delta_x};

    `PGR_ASSERT(a_begin_is_drag, i_clk, i_rst_n,
        (o_m_tvalid && !o_m_tuser[GEST_W]) |-> (o_m_tuser[GEST_W-1:0] == GEST_DRAG),
        "drag began report carries a gesture other than drag")
    `PGR_ASSERT(a_down_arms_press, i_clk, i_rst_n,
        (w_proc && r_in.mode == MODE_DOWN) |=> (r_phase == PH_POSSIBLE),
        "press event did not arm the press phase")
    `PGR_ASSERT(a_changed_is_drag, i_clk, i_rst_n,
        (r_phase == PH_CHANGED) |-> (r_kind == KD_DRAG),
        "drag changed phase without a drag as last gesture")
    `PGR_ASSERT(a_emit_reaches_output, i_clk, i_rst_n,
        (w_proc && w_emit) |=> o_m_tvalid,
        "a produced report did not reach the output register")
    `PGR_ASSERT_ALWAYS(a_empty_input_ready, i_clk,
        (i_rst_n && !r_in_valid) |-> o_s_tready,
        "empty input register refuses a transaction")

endmodule
